// ----- hdl/graph_bfs_order_macros.svh -----
// assertion helpers for the block that checks itself
`ifndef GRAPH_BFS_ORDER_MACROS_SVH
`define GRAPH_BFS_ORDER_MACROS_SVH

// plain property, sampled on clk, off while in reset
`define GBO_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// implication form
`define GBO_ASSERT_IMP(name, pre, con, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (con)) \
		else $error(msg);

`endif

// ----- hdl/gbo_pkg.sv -----
`default_nettype none

package gbo_pkg;

	localparam int VTX_W            = 4;
	localparam int CNT_W            = 5;
	localparam int MAX_VERTICES_DEF = 16;

	localparam logic [CNT_W-1:0] VERTEX_COUNT_RST = 5'd16;

	typedef enum logic [0:0] {
		OP_EDGE = 1'b0,
		OP_BFS  = 1'b1
	} opcode_t;

endpackage

`default_nettype wire

// ----- hdl/gbo_if.sv -----
`default_nettype none

// command channel
interface gbo_in_if;
	logic                      valid;
	logic                      ready;
	gbo_pkg::opcode_t          opcode;
	logic [gbo_pkg::VTX_W-1:0] vertex_a;
	logic [gbo_pkg::VTX_W-1:0] vertex_b;
	logic                      edge_present;

	modport source (output valid, opcode, vertex_a, vertex_b, edge_present, input ready);
	modport sink (input valid, opcode, vertex_a, vertex_b, edge_present, output ready);
endinterface

// visit order channel
interface gbo_out_if;
	logic                      valid;
	logic                      ready;
	logic [gbo_pkg::VTX_W-1:0] visited_vertex;
	logic                      last;
	logic                      error;

	modport source (output valid, visited_vertex, last, error, input ready);
	modport sink (input valid, visited_vertex, last, error, output ready);
endinterface

`default_nettype wire

// ----- hdl/graph_bfs_order.sv -----
// Breadth-first search over a small undirected graph held as a symmetric adjacency bit
// matrix (cleared by reset). A command word with opcode OP_EDGE sets or clears the edge
// (vertex_a, vertex_b) and returns nothing; an endpoint at or above vertex_count drops
// the write. A command word with opcode OP_BFS starts a search at vertex_a and returns
// one word per reached vertex in visit order, neighbours taken in ascending index order,
// with last set on the final word. A start vertex at or above vertex_count returns a
// single word with error and last set. The block takes no command while a search runs.
// A search spends, per visited vertex, a dequeue step, a scan step for each newly found
// neighbour, a closing scan step and a hand-out step that holds the word until taken.
// Neighbours come from the single lowest-set-bit picker, which moves one neighbour into
// the queue per cycle. vertex_count is to be written by the user only while the block
// idles; the block itself does not enforce this.
`default_nettype none

module graph_bfs_order #(
	parameter int MAX_VERTICES = gbo_pkg::MAX_VERTICES_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_we,
	input  wire logic [gbo_pkg::CNT_W-1:0] cfg_wdata,
	gbo_in_if.sink                         cmd,
	gbo_out_if.source                      rsp
);

	// only vertices 0..15 can be addressed, so rows past that would stay empty
	localparam int ROWS = (MAX_VERTICES < 16) ? MAX_VERTICES : 16;
	localparam int IW   = $clog2(ROWS);
	localparam int QW   = IW + 1;

	// sequencer states
	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,  // waiting for a command word
		ST_DEQ  = 4'b0010,  // pop a vertex, build its fresh-neighbour mask
		ST_SCAN = 4'b0100,  // push one fresh neighbour per cycle
		ST_EMIT = 4'b1000   // hold the result word until taken
	} state_t;

	state_t state_q;

	logic [gbo_pkg::CNT_W-1:0] vertex_count_q;

	// adjacency matrix and search state
	logic [ROWS-1:0] adj_q [ROWS];
	logic [ROWS-1:0] visited_q;
	logic [ROWS-1:0] fresh_q;
	logic [IW-1:0]   queue_q [ROWS];
	logic [QW-1:0]   head_q;
	logic [QW-1:0]   tail_q;

	// output register
	logic                      out_valid_q;
	logic [gbo_pkg::VTX_W-1:0] out_vertex_q;
	logic                      out_last_q;
	logic                      out_error_q;

	logic          cmd_fire;
	logic          a_ok;
	logic          b_ok;
	logic [IW-1:0] a_idx;
	logic [IW-1:0] b_idx;
	logic [IW-1:0] cur;
	logic [ROWS-1:0] in_range;
	logic [ROWS-1:0] pick_bit;
	logic [IW-1:0]   pick_idx;

	// search bookkeeping seen by the checks
	logic          in_search;
	logic [QW-1:0] seen_cnt;

	assign cmd_fire = cmd.valid && cmd.ready;
	assign cmd.ready = (state_q == ST_IDLE);

	assign rsp.valid          = out_valid_q;
	assign rsp.visited_vertex = out_vertex_q;
	assign rsp.last           = out_last_q;
	assign rsp.error          = out_error_q;

	// an endpoint counts only below both the programmed count and the built size
	assign a_ok = ({1'b0, cmd.vertex_a} < vertex_count_q) && (int'(cmd.vertex_a) < ROWS);
	assign b_ok = ({1'b0, cmd.vertex_b} < vertex_count_q) && (int'(cmd.vertex_b) < ROWS);
	assign a_idx = cmd.vertex_a[IW-1:0];
	assign b_idx = cmd.vertex_b[IW-1:0];

	// vertex at the queue head
	assign cur = queue_q[head_q[IW-1:0]];

	assign in_search = state_q inside {ST_DEQ, ST_SCAN};
	assign seen_cnt  = QW'($countones(visited_q));

	// columns that a search may follow
	always_comb begin
		for (int i = 0; i < ROWS; i++) begin
			in_range[i] = (gbo_pkg::CNT_W'(i) < vertex_count_q);
		end
	end

	// shared unit: lowest set bit of the fresh mask and its index
	assign pick_bit = fresh_q & (~fresh_q + 1'b1);

	always_comb begin
		pick_idx = '0;
		for (int i = 0; i < ROWS; i++) begin
			if (pick_bit[i]) begin
				pick_idx = pick_idx | IW'(i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_count_q <= gbo_pkg::VERTEX_COUNT_RST;
		end else if (cfg_we) begin
			vertex_count_q <= cfg_wdata;
		end
	end

	// edge writes touch both rows of the pair in the same cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < ROWS; r++) begin
				adj_q[r] <= '0;
			end
		end else if (cmd_fire && cmd.opcode == gbo_pkg::OP_EDGE && a_ok && b_ok) begin
			adj_q[a_idx][b_idx] <= cmd.edge_present;
			adj_q[b_idx][a_idx] <= cmd.edge_present;
		end
	end

	// vertex queue, no reset: every entry is written before a search reads it
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE) begin
			queue_q[0] <= a_idx;
		end else if (state_q == ST_SCAN && fresh_q != '0) begin
			queue_q[tail_q[IW-1:0]] <= pick_idx;
		end
	end

	// fresh mask is payload, loaded before each scan
	always_ff @(posedge clk) begin
		if (state_q == ST_DEQ) begin
			fresh_q <= adj_q[cur] & ~visited_q & in_range;
		end else if (state_q == ST_SCAN) begin
			fresh_q <= fresh_q & ~pick_bit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			visited_q    <= '0;
			head_q       <= '0;
			tail_q       <= '0;
			out_valid_q  <= 1'b0;
			out_vertex_q <= '0;
			out_last_q   <= 1'b0;
			out_error_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd_fire && cmd.opcode == gbo_pkg::OP_BFS) begin
						if (a_ok) begin
							// seed the search with the start vertex
							visited_q <= ROWS'(1) << a_idx;
							head_q    <= '0;
							tail_q    <= QW'(1);
							state_q   <= ST_DEQ;
						end else begin
							// bad start vertex: one flagged word
							out_valid_q  <= 1'b1;
							out_vertex_q <= '0;
							out_last_q   <= 1'b1;
							out_error_q  <= 1'b1;
							state_q      <= ST_EMIT;
						end
					end
				end
				ST_DEQ: begin
					out_vertex_q <= gbo_pkg::VTX_W'(cur);
					head_q       <= head_q + 1'b1;
					state_q      <= ST_SCAN;
				end
				ST_SCAN: begin
					if (fresh_q != '0) begin
						visited_q <= visited_q | pick_bit;
						tail_q    <= tail_q + 1'b1;
					end else begin
						// queue fully extended for this vertex, so last is known now
						out_valid_q <= 1'b1;
						out_last_q  <= (head_q == tail_q);
						out_error_q <= 1'b0;
						state_q     <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (rsp.ready) begin
						out_valid_q <= 1'b0;
						state_q     <= out_last_q ? ST_IDLE : ST_DEQ;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`include "graph_bfs_order_macros.svh"

	// no result may be pending while new commands are taken
	`GBO_ASSERT_IMP(a_idle_no_result, cmd.ready, !rsp.valid, "result pending while idle")

	// the queue never pops past its tail
	`GBO_ASSERT(a_head_le_tail, head_q <= tail_q, "queue head passed tail")

	// every visited vertex was queued exactly once
	`GBO_ASSERT_IMP(a_visited_vs_tail, in_search, seen_cnt == tail_q, "visited and fill disagree")

endmodule

`default_nettype wire

// ----- tb/graph_bfs_order_tb.sv -----
`default_nettype none

module graph_bfs_order_tb;

	timeunit 1ns;
	timeprecision 1ps;

	// cycles without any accepted word before the run is declared hung
	localparam int STALL_LIMIT   = 2000;
	// an edge write returns nothing, so give the block time to finish it
	localparam int SETTLE_CYCLES = 8;
	localparam int SCRIPT_ROWS   = 27;

	// one word on the visit order channel
	typedef struct packed {
		logic [gbo_pkg::VTX_W-1:0] vertex;
		logic                      last;
		logic                      error;
	} visit_word_t;

	typedef enum logic {
		ROW_CMD,
		ROW_COUNT
	} row_kind_t;

	// directed script row: either a vertex_count write or a command word,
	// optionally with the single answer typed in
	typedef struct packed {
		row_kind_t                 kind;
		logic [gbo_pkg::CNT_W-1:0] count;
		gbo_pkg::opcode_t          op;
		logic [gbo_pkg::VTX_W-1:0] a;
		logic [gbo_pkg::VTX_W-1:0] b;
		logic                      e;
		logic                      typed;
		logic [gbo_pkg::VTX_W-1:0] x_vertex;
		logic                      x_last;
		logic                      x_error;
	} script_row_t;

	logic                      clk;
	logic                      arst_n;
	logic                      cfg_we;
	logic [gbo_pkg::CNT_W-1:0] cfg_wdata;

	gbo_in_if  cmd_ch ();
	gbo_out_if rsp_ch ();

	graph_bfs_order i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd_ch),
		.rsp       (rsp_ch)
	);

	// shadow of the graph: adjacency rows and the vertex count in use
	logic [15:0]               adj_rows [16];
	logic [gbo_pkg::CNT_W-1:0] graph_size;

	visit_word_t expected_visits [$];
	visit_word_t predicted_visits [$];

	int fail_count;
	int idle_cycles;
	int send_idle_pct;
	int recv_stall_pct;

	// directed part: reset state, far corners of the vertex range, self loop,
	// edge removal, dropped writes, counts of zero, one, and above capacity
	script_row_t script [SCRIPT_ROWS] = '{
		// empty matrix: the start vertex is visited alone
		'{ROW_CMD,   5'd0,  gbo_pkg::OP_BFS,  4'd0,  4'd0,  1'b0, 1'b1, 4'd0,  1'b1, 1'b0},
		'{ROW_CMD,   5'd0,  gbo_pkg::OP_BFS,  4'd15, 4'd15, 1'b1, 1'b1, 4'd15, 1'b1, 1'b0},
		'{ROW_CMD,   5'd0,  gbo_pkg::OP_EDGE, 4'd0,  4'd15, 1'b1, 1'b0, 4'd0,  1'b0, 1'b0},
		// self loop is stored but never followed
		'{ROW_CMD,   5'd0,  gbo_pkg::OP_EDGE, 4'd15, 4'd15, 1'b1, 1'b0, 4'd0,  1'b0, 1'b0},
		'{ROW_CMD,   5'd0,  gbo_pkg::OP_BFS,  4'd15, 4'd0,  1'b0, 1'b0, 4'd0,  1'b0, 1'b0},
		'{ROW_CMD,   5'd0,  gbo_pkg::OP_EDGE, 4'd1,  4'd2,  1'b1, 1'b0, 4'd0,  1'b0, 1'b0},
		'{ROW_CMD,   5'd0,  gbo_pkg::OP_EDGE, 4'd2,  4'd0,  1'b1, 1'b0, 4'd0,  1'b0, 1'b0},
		'{ROW_CMD,   5'd0,  gbo_pkg::OP_EDGE, 4'd3,  4'd2,  1'b1, 1'b0, 4'd0,  1'b0, 1'b0},
		'{ROW_CMD,   5'd0,  gbo_pkg::OP_EDGE, 4'd14, 4'd3,  1'b1, 1'b0, 4'd0,  1'b0, 1'b0},
		'{ROW_CMD,   5'd0,  gbo_pkg::OP_BFS,  4'd0,  4'd9,  1'b1, 1'b0, 4'd0,  1'b0, 1'b0},
		// remove an edge, written with the endpoints swapped
		'{ROW_CMD,   5'd0,  gbo_pkg::OP_EDGE, 4'd15, 4'd0,  1'b0, 1'b0, 4'd0,  1'b0, 1'b0},
		'{ROW_CMD,   5'd0,  gbo_pkg::OP_BFS,  4'd15, 4'd0,  1'b0, 1'b0, 4'd0,  1'b0, 1'b0},
		// lowered count: start out of range gives the error word
		'{ROW_COUNT, 5'd4,  gbo_pkg::OP_EDGE, 4'd0,  4'd0,  1'b0, 1'b0, 4'd0,  1'b0, 1'b0},
		'{ROW_CMD,   5'd0,  gbo_pkg::OP_BFS,  4'd4,  4'd0,  1'b0, 1'b1, 4'd0,  1'b1, 1'b1},
		'{ROW_CMD,   5'd0,  gbo_pkg::OP_BFS,  4'd15, 4'd0,  1'b0, 1'b1, 4'd0,  1'b1, 1'b1},
		// writes with an endpoint out of range are dropped
		'{ROW_CMD,   5'd0,  gbo_pkg::OP_EDGE, 4'd3,  4'd14, 1'b0, 1'b0, 4'd0,  1'b0, 1'b0},
		'{ROW_CMD,   5'd0,  gbo_pkg::OP_EDGE, 4'd5,  4'd1,  1'b1, 1'b0, 4'd0,  1'b0, 1'b0},
		'{ROW_CMD,   5'd0,  gbo_pkg::OP_BFS,  4'd0,  4'd0,  1'b0, 1'b0, 4'd0,  1'b0, 1'b0},
		// count above capacity saturates, the edge to 14 is back in reach
		'{ROW_COUNT, 5'd31, gbo_pkg::OP_EDGE, 4'd0,  4'd0,  1'b0, 1'b0, 4'd0,  1'b0, 1'b0},
		'{ROW_CMD,   5'd0,  gbo_pkg::OP_BFS,  4'd3,  4'd0,  1'b0, 1'b0, 4'd0,  1'b0, 1'b0},
		// count of zero: every start is out of range
		'{ROW_COUNT, 5'd0,  gbo_pkg::OP_EDGE, 4'd0,  4'd0,  1'b0, 1'b0, 4'd0,  1'b0, 1'b0},
		'{ROW_CMD,   5'd0,  gbo_pkg::OP_BFS,  4'd0,  4'd0,  1'b0, 1'b1, 4'd0,  1'b1, 1'b1},
		'{ROW_CMD,   5'd0,  gbo_pkg::OP_EDGE, 4'd0,  4'd0,  1'b1, 1'b0, 4'd0,  1'b0, 1'b0},
		// single vertex graph
		'{ROW_COUNT, 5'd1,  gbo_pkg::OP_EDGE, 4'd0,  4'd0,  1'b0, 1'b0, 4'd0,  1'b0, 1'b0},
		'{ROW_CMD,   5'd0,  gbo_pkg::OP_BFS,  4'd0,  4'd0,  1'b0, 1'b1, 4'd0,  1'b1, 1'b0},
		'{ROW_CMD,   5'd0,  gbo_pkg::OP_BFS,  4'd1,  4'd0,  1'b0, 1'b1, 4'd0,  1'b1, 1'b1},
		'{ROW_COUNT, 5'd16, gbo_pkg::OP_EDGE, 4'd0,  4'd0,  1'b0, 1'b0, 4'd0,  1'b0, 1'b0}
	};

	always #5 clk = ~clk;

	// update the shadow graph for one command word and leave its visit
	// words, if any, in predicted_visits
	task automatic predict_command(gbo_pkg::opcode_t op, logic [gbo_pkg::VTX_W-1:0] a,
			logic [gbo_pkg::VTX_W-1:0] b, logic e);
		int                        n;
		int                        head;
		int                        tail;
		logic [15:0]               seen;
		logic [15:0]               reach;
		logic [15:0]               fresh;
		logic [gbo_pkg::VTX_W-1:0] fifo [16];
		logic [gbo_pkg::VTX_W-1:0] cur;
		visit_word_t               w;

		n = (graph_size > 5'd16) ? 16 : int'(graph_size);
		reach = (n >= 16) ? 16'hFFFF : ((16'd1 << n) - 16'd1);
		predicted_visits.delete();
		if (op == gbo_pkg::OP_EDGE) begin
			if (int'(a) < n && int'(b) < n) begin
				adj_rows[a][b] = e;
				adj_rows[b][a] = e;
			end
		end else if (int'(a) >= n) begin
			w.vertex = '0;
			w.last   = 1'b1;
			w.error  = 1'b1;
			predicted_visits.push_back(w);
		end else begin
			seen    = 16'd1 << a;
			fifo[0] = a;
			head    = 0;
			tail    = 1;
			while (head < tail && predicted_visits.size() < 16) begin
				cur = fifo[head];
				head++;
				// neighbours in ascending order, marked as soon as they are queued
				fresh = adj_rows[cur] & ~seen & reach;
				for (int i = 0; i < n; i++) begin
					if (fresh[i]) begin
						seen[i] = 1'b1;
						if (tail < 16) begin
							fifo[tail] = gbo_pkg::VTX_W'(i);
							tail++;
						end
					end
				end
				w.vertex = cur;
				w.last   = (head == tail) || (predicted_visits.size() == 15);
				w.error  = 1'b0;
				predicted_visits.push_back(w);
			end
		end
	endtask

	// present one command word, with random idle cycles ahead of it, and hold
	// it until the block takes it
	task automatic send_command(gbo_pkg::opcode_t op, logic [gbo_pkg::VTX_W-1:0] a,
			logic [gbo_pkg::VTX_W-1:0] b, logic e, logic typed, visit_word_t typed_word);
		while ($urandom_range(99) < send_idle_pct) begin
			cmd_ch.valid <= 1'b0;
			@(posedge clk);
		end
		cmd_ch.valid        <= 1'b1;
		cmd_ch.opcode       <= op;
		cmd_ch.vertex_a     <= a;
		cmd_ch.vertex_b     <= b;
		cmd_ch.edge_present <= e;
		// the block answers only after taking the word, so queue the answer now
		predict_command(op, a, b, e);
		if (typed)
			expected_visits.push_back(typed_word);
		else
			foreach (predicted_visits[i])
				expected_visits.push_back(predicted_visits[i]);
		@(posedge clk);
		while (!cmd_ch.ready)
			@(posedge clk);
	endtask

	// stop sending, wait for every visit word, then let a trailing edge
	// write settle
	task automatic drain;
		cmd_ch.valid <= 1'b0;
		while (expected_visits.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// vertex_count is only touched while the block sits idle
	task automatic write_vertex_count(logic [gbo_pkg::CNT_W-1:0] value);
		drain();
		cfg_we     <= 1'b1;
		cfg_wdata  <= value;
		graph_size  = value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// mostly edge writes inside the graph so the searches reach far, with a
	// few endpoints and start vertices thrown out of range
	task automatic run_random_phase(logic [gbo_pkg::CNT_W-1:0] count, int idle_pct,
			int stall_pct, int words);
		int                        span;
		logic [gbo_pkg::VTX_W-1:0] a;
		logic [gbo_pkg::VTX_W-1:0] b;
		logic                      e;
		visit_word_t               none;

		none = '0;
		write_vertex_count(count);
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		span = (count > 5'd16) ? 16 : int'(count);
		repeat (words) begin
			if (span == 0 || $urandom_range(9) == 0)
				a = gbo_pkg::VTX_W'($urandom_range(15));
			else
				a = gbo_pkg::VTX_W'($urandom_range(span - 1));
			if (span == 0 || $urandom_range(9) == 0)
				b = gbo_pkg::VTX_W'($urandom_range(15));
			else
				b = gbo_pkg::VTX_W'($urandom_range(span - 1));
			if ($urandom_range(99) < 68) begin
				// bias toward adding edges so the graph fills up
				e = ($urandom_range(99) < 75);
				send_command(gbo_pkg::OP_EDGE, a, b, e, 1'b0, none);
			end else begin
				e = 1'($urandom_range(1));
				send_command(gbo_pkg::OP_BFS, a, b, e, 1'b0, none);
			end
		end
	endtask

	// visit order checker and receiver stall generator
	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (expected_visits.size() == 0) begin
				$display("%0t: unexpected word: expected none, got vertex %0d last %0d error %0d",
					$time, rsp_ch.visited_vertex, rsp_ch.last, rsp_ch.error);
				fail_count++;
			end else begin
				visit_word_t want;
				want = expected_visits.pop_front();
				if (rsp_ch.visited_vertex !== want.vertex) begin
					$display("%0t: visited_vertex mismatch: expected %0d, got %0d",
						$time, want.vertex, rsp_ch.visited_vertex);
					fail_count++;
				end
				if (rsp_ch.last !== want.last) begin
					$display("%0t: last mismatch: expected %0d, got %0d",
						$time, want.last, rsp_ch.last);
					fail_count++;
				end
				if (rsp_ch.error !== want.error) begin
					$display("%0t: error mismatch: expected %0d, got %0d",
						$time, want.error, rsp_ch.error);
					fail_count++;
				end
			end
		end
		rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// hang detector: any accepted word on either channel restarts the count
	always @(posedge clk) begin
		if (!arst_n || (cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("FAILURE");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		visit_word_t typed_word;

		clk                 = 1'b0;
		arst_n              = 1'b0;
		cfg_we              = 1'b0;
		cfg_wdata           = '0;
		cmd_ch.valid        = 1'b0;
		cmd_ch.opcode       = gbo_pkg::OP_EDGE;
		cmd_ch.vertex_a     = '0;
		cmd_ch.vertex_b     = '0;
		cmd_ch.edge_present = 1'b0;
		rsp_ch.ready        = 1'b0;
		fail_count          = 0;
		idle_cycles         = 0;
		send_idle_pct       = 0;
		recv_stall_pct      = 0;
		graph_size          = gbo_pkg::VERTEX_COUNT_RST;
		foreach (adj_rows[i])
			adj_rows[i] = '0;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed script, back to back on both sides
		for (int r = 0; r < SCRIPT_ROWS; r++) begin
			if (script[r].kind == ROW_COUNT) begin
				write_vertex_count(script[r].count);
			end else begin
				typed_word.vertex = script[r].x_vertex;
				typed_word.last   = script[r].x_last;
				typed_word.error  = script[r].x_error;
				send_command(script[r].op, script[r].a, script[r].b, script[r].e,
					script[r].typed, typed_word);
			end
		end

		// random traffic under each idling mix
		run_random_phase(5'd16, 0, 0, 45);
		run_random_phase(gbo_pkg::CNT_W'($urandom_range(1, 15)), 50, 0, 45);
		run_random_phase(5'd16, 0, 50, 45);
		run_random_phase(gbo_pkg::CNT_W'($urandom_range(17, 31)), 22, 22, 45);

		drain();
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

`default_nettype wire
